// ----- sv/gcod_pkg.sv -----
// Package for the grid cell occupancy detector: shared types and constants.
// Holds the configuration register map, the queue item layout and the cell accumulator word.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package gcod_pkg;

    // Configuration register indexes, in register map order.
    typedef enum logic [2:0] {
        CFG_CELL_WIDTH      = 3'd0,
        CFG_CELL_HEIGHT     = 3'd1,
        CFG_CELLS_ACROSS    = 3'd2,
        CFG_CELLS_DOWN      = 3'd3,
        CFG_COUNT_THRESHOLD = 3'd4,
        CFG_SAMPLE_ROW      = 3'd5,
        CFG_SAMPLE_COL      = 3'd6
    } cfg_index_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Register values after reset.
    localparam logic [6:0]  RST_CELL_WIDTH      = 7'd25;
    localparam logic [6:0]  RST_CELL_HEIGHT     = 7'd25;
    localparam logic [6:0]  RST_CELLS_ACROSS    = 7'd16;
    localparam logic [9:0]  RST_CELLS_DOWN      = 10'd16;
    localparam logic [12:0] RST_COUNT_THRESHOLD = 13'd64;
    localparam logic [5:0]  RST_SAMPLE_ROW      = 6'd12;
    localparam logic [5:0]  RST_SAMPLE_COL      = 6'd12;

    // The nonzero count saturates at its all-ones value.
    localparam logic [12:0] COUNT_MAX = 13'h1FFF;

    // Depth of the queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [6:0]  cell_width;
        logic [6:0]  cell_height;
        logic [6:0]  cells_across;
        logic [9:0]  cells_down;
        logic [12:0] count_threshold;
        logic [5:0]  sample_row;
        logic [5:0]  sample_col;
    } cfg_t;

    // Classification of one pixel, made by the front.
    typedef struct packed {
        logic is_first;    // first pixel of its cell: clears the accumulator
        logic sample_hit;  // pixel sits at the sample offset
        logic cell_end;    // bottom-right pixel of its cell
        logic last_cell;   // cell is the bottom-right cell of the grid
    } item_flags_t;

    typedef struct packed {
        item_flags_t flags;
        logic [9:0]  cell_y;
        logic [5:0]  cell_x;
        logic [7:0]  pixel;
    } item_info_t;

    // Per-column accumulator word kept in the back's memory.
    typedef struct packed {
        logic [12:0] count;
        logic [7:0]  sample;
    } acc_t;

endpackage

`default_nettype wire

// ----- sv/grid_cell_occupancy_detector_top.sv -----
// Top level of the grid cell occupancy detector: configuration registers, front, queue, back.
// Depends on gcod_pkg, gcod_front, gcod_queue and gcod_back.
//
// Usage: pixels arrive in raster order on the s_ channel, one per beat, with
// s_tuser marking the first pixel of a frame. The frame is split into a grid of
// cells; for each cell the block counts nonzero pixels and keeps the pixel at the
// configured sample offset. When a cell's bottom-right pixel arrives and its count
// exceeds count_threshold, one result beat leaves on the m_ channel with the cell's
// column, row and sample; m_tlast flags the bottom-right cell of the grid.
// Throughput is one pixel per clock while the result side does not stall. The edge
// that moves a cell's last pixel from the queue head into the update stage also
// reads its column from memory; the result register is then loaded from the update
// stage. The single read port of the column accumulator memory is read one stage
// ahead of its update, which keeps that rate.
// While a result waits on a low m_tready, the result register holds, the back
// stalls, the four-entry queue fills and s_tready then drops. Configuration is
// written over the cfg_ channel, which is always ready; write only while no pixel
// is in flight. Reset restores the register defaults, zeroes the raster position
// and marks all column accumulators as unwritten; no clearing pass is needed.
`default_nettype none

module grid_cell_occupancy_detector_top import gcod_pkg::*; #(
    parameter int MAX_CELLS_ACROSS = 64,
    parameter int MAX_CELL_SIZE    = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Pixel input channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] pixel
    input  wire logic [0:0]            s_tuser,   // [0] frame_start
    // Result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata,   // [5:0] cell_x, [15:6] cell_y, [23:16] sample
    output logic                       m_tlast,   // last_cell
    // Configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_W = (MAX_CELLS_ACROSS > 1) ? $clog2(MAX_CELLS_ACROSS) : 1;
    localparam int INFO_W = $bits(item_info_t);
    localparam int QW     = INFO_W + SLOT_W;

    cfg_t cfg_reg;

    logic              s_accept;
    item_info_t        f_info;
    logic [SLOT_W-1:0] f_slot;
    logic [QW-1:0]     q_head;
    logic              q_not_empty, q_pop;
    item_info_t        a_info;
    logic [SLOT_W-1:0] a_slot;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;

    // Configuration registers, written one beat at a time.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cell_width      <= RST_CELL_WIDTH;
            cfg_reg.cell_height     <= RST_CELL_HEIGHT;
            cfg_reg.cells_across    <= RST_CELLS_ACROSS;
            cfg_reg.cells_down      <= RST_CELLS_DOWN;
            cfg_reg.count_threshold <= RST_COUNT_THRESHOLD;
            cfg_reg.sample_row      <= RST_SAMPLE_ROW;
            cfg_reg.sample_col      <= RST_SAMPLE_COL;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CELL_WIDTH:      cfg_reg.cell_width      <= cfg_data[6:0];
                CFG_CELL_HEIGHT:     cfg_reg.cell_height     <= cfg_data[6:0];
                CFG_CELLS_ACROSS:    cfg_reg.cells_across    <= cfg_data[6:0];
                CFG_CELLS_DOWN:      cfg_reg.cells_down      <= cfg_data[9:0];
                CFG_COUNT_THRESHOLD: cfg_reg.count_threshold <= cfg_data[12:0];
                CFG_SAMPLE_ROW:      cfg_reg.sample_row      <= cfg_data[5:0];
                CFG_SAMPLE_COL:      cfg_reg.sample_col      <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Position tracking and classification.
    gcod_front #(
        .MAX_CELLS_ACROSS (MAX_CELLS_ACROSS),
        .MAX_CELL_SIZE    (MAX_CELL_SIZE),
        .SLOT_W           (SLOT_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .accept      (s_accept),
        .pixel       (s_tdata),
        .frame_start (s_tuser[0]),
        .item_info   (f_info),
        .item_slot   (f_slot)
    );

    // Decoupling queue.
    gcod_queue #(
        .DATA_W (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_accept),
        .push_data ({f_slot, f_info}),
        .not_full  (s_tready),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_data (q_head)
    );

    assign a_info = q_head[INFO_W-1:0];
    assign a_slot = q_head[QW-1:INFO_W];

    // Accumulation and result output.
    gcod_back #(
        .MAX_CELLS_ACROSS (MAX_CELLS_ACROSS),
        .SLOT_W           (SLOT_W)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .count_threshold (cfg_reg.count_threshold),
        .a_valid         (q_not_empty),
        .a_info          (a_info),
        .a_slot          (a_slot),
        .a_pop           (q_pop),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast)
    );

endmodule

`default_nettype wire

// ----- sv/gcod_front.sv -----
// Front of the grid cell occupancy detector: tracks the raster position and classifies pixels.
// Produces one classified item per accepted pixel for the queue.
// Depends on gcod_pkg.
`default_nettype none

module gcod_front import gcod_pkg::*; #(
    parameter int MAX_CELLS_ACROSS = 64,
    parameter int MAX_CELL_SIZE    = 64,
    parameter int SLOT_W           = 6
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cfg_t              cfg,
    input  wire logic              accept,
    input  wire logic [7:0]        pixel,
    input  wire logic              frame_start,
    output item_info_t             item_info,
    output logic [SLOT_W-1:0]      item_slot
);

    localparam int PX_W = (MAX_CELL_SIZE > 1) ? $clog2(MAX_CELL_SIZE) : 1;
    localparam int SW   = (PX_W + 1 > 7) ? PX_W + 1 : 7;
    localparam int CCW  = (SLOT_W + 1 > 7) ? SLOT_W + 1 : 7;

    logic [PX_W-1:0]   px_reg, px_next, py_reg, py_next;
    logic [SLOT_W-1:0] col_reg, col_next;
    logic [9:0]        row_reg, row_next;

    logic [PX_W-1:0]   px_cur, py_cur;
    logic [SLOT_W-1:0] col_cur;
    logic [9:0]        row_cur;
    logic [SW-1:0]     w, h, w_raw, h_raw, px_inc, py_inc;
    logic [CCW-1:0]    ca, ca_raw, col_inc;
    logic [9:0]        cd;
    logic [10:0]       row_inc;
    logic              px_wrap, py_wrap, col_wrap, row_wrap;

    // A frame start zeroes the position before the pixel is classified.
    always_comb begin
        px_cur  = frame_start ? '0 : px_reg;
        py_cur  = frame_start ? '0 : py_reg;
        col_cur = frame_start ? '0 : col_reg;
        row_cur = frame_start ? '0 : row_reg;
    end

    // Clamp the grid sizes to their legal ranges.
    always_comb begin
        w_raw  = SW'(cfg.cell_width);
        h_raw  = SW'(cfg.cell_height);
        ca_raw = CCW'(cfg.cells_across);
        if (w_raw == '0) begin
            w = SW'(1);
        end else if (w_raw > SW'(MAX_CELL_SIZE)) begin
            w = SW'(MAX_CELL_SIZE);
        end else begin
            w = w_raw;
        end
        if (h_raw == '0) begin
            h = SW'(1);
        end else if (h_raw > SW'(MAX_CELL_SIZE)) begin
            h = SW'(MAX_CELL_SIZE);
        end else begin
            h = h_raw;
        end
        if (ca_raw == '0) begin
            ca = CCW'(1);
        end else if (ca_raw > CCW'(MAX_CELLS_ACROSS)) begin
            ca = CCW'(MAX_CELLS_ACROSS);
        end else begin
            ca = ca_raw;
        end
        cd = (cfg.cells_down == '0) ? 10'd1 : cfg.cells_down;
    end

    // Wrap conditions of the four position counters.
    always_comb begin
        px_inc   = SW'(px_cur) + SW'(1);
        py_inc   = SW'(py_cur) + SW'(1);
        col_inc  = CCW'(col_cur) + CCW'(1);
        row_inc  = {1'b0, row_cur} + 11'd1;
        px_wrap  = (px_inc >= w);
        py_wrap  = (py_inc >= h);
        col_wrap = (col_inc >= ca);
        row_wrap = (row_inc >= {1'b0, cd});
    end

    // Classify the pixel at its current position.
    always_comb begin
        item_info.pixel            = pixel;
        item_info.cell_x           = 6'(col_cur);
        item_info.cell_y           = row_cur;
        item_info.flags.is_first   = (px_cur == '0) && (py_cur == '0);
        item_info.flags.sample_hit = (SW'(cfg.sample_row) < h) && (SW'(cfg.sample_col) < w)
                                   && (SW'(py_cur) == SW'(cfg.sample_row))
                                   && (SW'(px_cur) == SW'(cfg.sample_col));
        item_info.flags.cell_end   = px_wrap && py_wrap;
        item_info.flags.last_cell  = col_wrap && row_wrap;
        item_slot                  = col_cur;
    end

    // Advance the raster position on every accepted beat.
    always_comb begin
        px_next  = px_reg;
        py_next  = py_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            px_next  = px_wrap ? '0 : PX_W'(px_inc);
            py_next  = py_cur;
            col_next = col_cur;
            row_next = row_cur;
            if (px_wrap) begin
                col_next = col_wrap ? '0 : SLOT_W'(col_inc);
                if (col_wrap) begin
                    py_next = py_wrap ? '0 : PX_W'(py_inc);
                    if (py_wrap) begin
                        row_next = row_wrap ? '0 : row_inc[9:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_reg  <= '0;
            py_reg  <= '0;
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/gcod_queue.sv -----
// Short first-word-fall-through queue between front and back of the detector.
// Lets the pixel side and the result side stall independently.
// Depends on gcod_pkg for its depth.
`default_nettype none

module gcod_queue import gcod_pkg::*; #(
    parameter int DATA_W = 34
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   not_full,
    input  wire logic              pop,
    output logic                   not_empty,
    output logic [DATA_W-1:0]      head_data
);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg, fill_next;

    always_comb begin
        not_full  = (fill_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
        not_empty = (fill_reg != '0);
        head_data = entry_reg[rd_ptr_reg];
    end

    // Fill level follows pushes and pops; both may happen in one cycle.
    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + (QPTR_W + 1)'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    // Entry storage carries payload only.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/gcod_back.sv -----
// Back of the grid cell occupancy detector: per-column accumulators and the result register.
// Reads the column memory one stage ahead, updates it, and reports occupied cells.
// Depends on gcod_pkg.
`default_nettype none

module gcod_back import gcod_pkg::*; #(
    parameter int MAX_CELLS_ACROSS = 64,
    parameter int SLOT_W           = 6
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [12:0]       count_threshold,
    input  wire logic              a_valid,
    input  wire item_info_t        a_info,
    input  wire logic [SLOT_W-1:0] a_slot,
    output logic                   a_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata,
    output logic                   m_tlast
);

    // Accumulator memory, one word per cell column.
    acc_t acc_mem [MAX_CELLS_ACROSS];
    logic [MAX_CELLS_ACROSS-1:0] written_reg;

    // Update stage registers.
    logic              b_valid_reg;
    item_info_t        b_info_reg;
    logic [SLOT_W-1:0] b_slot_reg;
    acc_t              rd_data_reg;
    logic              rd_zero_reg;
    logic              byp_reg;
    acc_t              byp_data_reg;

    // Result register.
    logic        out_valid_reg;
    logic [5:0]  out_x_reg;
    logic [9:0]  out_y_reg;
    logic [7:0]  out_sample_reg;
    logic        out_last_reg;

    logic  adv;
    acc_t  base_acc, new_acc;
    logic  report;

    // The whole back moves when the result register is free or being drained.
    always_comb begin
        adv   = !out_valid_reg || m_tready;
        a_pop = adv && a_valid;
    end

    // Pick the accumulator source: cell start, forwarded write, unwritten entry or memory.
    always_comb begin
        if (b_info_reg.flags.is_first) begin
            base_acc = '0;
        end else if (byp_reg) begin
            base_acc = byp_data_reg;
        end else if (rd_zero_reg) begin
            base_acc = '0;
        end else begin
            base_acc = rd_data_reg;
        end
        new_acc = base_acc;
        if ((b_info_reg.pixel != 8'd0) && (base_acc.count < COUNT_MAX)) begin
            new_acc.count = base_acc.count + 13'd1;
        end
        if (b_info_reg.flags.sample_hit) begin
            new_acc.sample = b_info_reg.pixel;
        end
        report = b_info_reg.flags.cell_end && (new_acc.count > count_threshold);
    end

    // Memory read for the next item and write-back of the current one.
    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_data_reg <= acc_mem[a_slot];
            if (b_valid_reg) begin
                acc_mem[b_slot_reg] <= new_acc;
            end
        end
    end

    // Stage payload and forwarding when the next item hits the column being written.
    always_ff @(posedge aclk) begin
        if (adv) begin
            b_info_reg   <= a_info;
            b_slot_reg   <= a_slot;
            byp_data_reg <= new_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            byp_reg     <= 1'b0;
            rd_zero_reg <= 1'b0;
            written_reg <= '0;
        end else if (adv) begin
            b_valid_reg <= a_valid;
            byp_reg     <= b_valid_reg && (b_slot_reg == a_slot);
            rd_zero_reg <= !written_reg[a_slot];
            if (b_valid_reg) begin
                written_reg[b_slot_reg] <= 1'b1;
            end
        end
    end

    // Result register toward the master side.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= b_valid_reg && report;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_x_reg      <= b_info_reg.cell_x;
            out_y_reg      <= b_info_reg.cell_y;
            out_sample_reg <= new_acc.sample;
            out_last_reg   <= b_info_reg.flags.last_cell;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_sample_reg, out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
